// ----- rtl/core/pfsm_pkg.sv -----
// shared types and constants of the per-thread frame sequence monitor
package pfsm_pkg;

    localparam int TID_BITS     = 10;
    localparam int FRAME_BITS   = 24;
    localparam int OUT_CNT_BITS = 32;

    // stream widths
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 184;

    // per-thread entry layout, counters follow from CNT_LSB upward
    localparam int SEEN_POS = 0;
    localparam int PREV_LSB = 1;
    localparam int CNT_LSB  = PREV_LSB + FRAME_BITS;

    typedef struct packed {
        logic                  frame_invalid;
        logic [FRAME_BITS-1:0] frame_number;
        logic [TID_BITS-1:0]   thread_id;
    } pfsm_item_t;

endpackage

// ----- rtl/core/pfsm_store.sv -----
// per-thread statistics memory with clearing sweep after reset
module pfsm_store #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 121
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data,
    output logic                 clearing
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 clr_busy_reg, clr_busy_next;
    logic [ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == ADDR_BITS'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // one write port, zeros while sweeping
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read before write on the same address
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

// ----- rtl/core/pfsm_update.sv -----
// per-thread entry update: sequence check and saturating counters
module pfsm_update
    import pfsm_pkg::*;
#(
    parameter int COUNTER_BITS = 32,
    parameter int ENTRY_BITS   = 121
) (
    input  pfsm_item_t              item,
    input  logic                    in_range,
    input  logic [ENTRY_BITS-1:0]   entry_in,
    output logic [ENTRY_BITS-1:0]   entry_out,
    output logic [COUNTER_BITS-1:0] thread_valid,
    output logic [COUNTER_BITS-1:0] thread_invalid,
    output logic [COUNTER_BITS-1:0] thread_break,
    output logic                    seq_break
);

    localparam int VAL_LSB = CNT_LSB;
    localparam int INV_LSB = CNT_LSB + COUNTER_BITS;
    localparam int BRK_LSB = CNT_LSB + 2 * COUNTER_BITS;

    logic                    old_seen;
    logic [FRAME_BITS-1:0]   old_prev;
    logic [COUNTER_BITS-1:0] old_valid, old_invalid, old_break;
    logic [COUNTER_BITS-1:0] new_valid, new_invalid, new_break;
    logic [FRAME_BITS:0]     prev_plus_one;
    logic                    brk;

    always_comb begin
        old_seen    = entry_in[SEEN_POS];
        old_prev    = entry_in[PREV_LSB +: FRAME_BITS];
        old_valid   = entry_in[VAL_LSB +: COUNTER_BITS];
        old_invalid = entry_in[INV_LSB +: COUNTER_BITS];
        old_break   = entry_in[BRK_LSB +: COUNTER_BITS];

        // no wrap: after the top frame number only zero continues
        prev_plus_one = {1'b0, old_prev} + 1'b1;
        brk = in_range && old_seen && (item.frame_number != '0)
              && ({1'b0, item.frame_number} != prev_plus_one);

        new_valid   = old_valid;
        new_invalid = old_invalid;
        new_break   = old_break;
        if (item.frame_invalid) begin
            if (old_invalid != '1) new_invalid = old_invalid + 1'b1;
        end else begin
            if (old_valid != '1) new_valid = old_valid + 1'b1;
        end
        if (brk && (old_break != '1)) begin
            new_break = old_break + 1'b1;
        end

        entry_out = {new_break, new_invalid, new_valid, item.frame_number, 1'b1};

        thread_valid   = in_range ? new_valid   : '0;
        thread_invalid = in_range ? new_invalid : '0;
        thread_break   = in_range ? new_break   : '0;
        seq_break      = brk;
    end

endmodule

// ----- rtl/core/per_thread_frame_sequence_monitor.sv -----
// top level of the per-thread frame sequence monitor
//
// input channel s_*: one frame header per transaction, thread id and frame
// number in s_tdata, the header's invalid flag in s_tuser
// result channel m_*: one transaction per header, with the updated counts of
// that header's thread, the out-of-sequence flag in m_tuser, and the global
// highest frame number and valid/invalid totals
// throughput: one header per cycle while results are taken, set by the single
// read-modify-write of the per-thread memory; a header that follows one of the
// same thread takes the just-written entry from a forwarding register
// path: the memory is read and the header registered into the update stage at
// the accepting edge; the update goes into the output register, raising
// m_tvalid, once that register is free or being drained
// reset: all statistics are cleared; the per-thread memory is swept one entry
// a cycle with s_tready low, after which headers flow
// stall: a held result keeps m_tvalid and its data; one more header is taken
// into the update stage, then s_tready drops until m_tready returns
module per_thread_frame_sequence_monitor
    import pfsm_pkg::*;
#(
    parameter int THREAD_COUNT = 1024,
    parameter int COUNTER_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [9:0] thread_id, [33:10] frame_number, [39:34] zero
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // [0] frame_invalid
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [31:0] thread_valid_frames, [63:32] thread_invalid_frames,
    // [95:64] thread_out_of_sequence, [119:96] highest_frame_seen,
    // [151:120] all_valid_frames, [183:152] all_invalid_frames
    output logic [M_TDATA_BITS-1:0] m_tdata,
    // [0] sequence_break
    output logic                    m_tuser
);

    localparam int ADDR_BITS  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int ENTRY_BITS = CNT_LSB + 3 * COUNTER_BITS;

    // input side
    pfsm_item_t in_item;
    logic       in_range;
    logic       s_accept;
    logic       clearing;

    // update stage
    logic                    s1_valid_reg, s1_valid_next;
    pfsm_item_t              s1_item_reg, s1_item_next;
    logic                    s1_range_reg, s1_range_next;
    logic                    fwd_hit_reg, fwd_hit_next;
    logic [ENTRY_BITS-1:0]   fwd_data_reg, fwd_data_next;
    logic                    s1_advance;
    logic [ENTRY_BITS-1:0]   rd_entry, cur_entry, new_entry;
    logic [COUNTER_BITS-1:0] t_valid, t_invalid, t_break;
    logic                    brk;
    logic                    wr_en;

    // global statistics
    logic [FRAME_BITS-1:0]   highest_reg, highest_next;
    logic [COUNTER_BITS-1:0] valid_total_reg, valid_total_next;
    logic [COUNTER_BITS-1:0] invalid_total_reg, invalid_total_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    assign in_item.thread_id     = s_tdata[TID_BITS-1:0];
    assign in_item.frame_number  = s_tdata[TID_BITS +: FRAME_BITS];
    assign in_item.frame_invalid = s_tuser;
    assign in_range = ({1'b0, in_item.thread_id} < (TID_BITS + 1)'(THREAD_COUNT));

    // stage moves on whenever the output register is free or being drained
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !clearing && (!s1_valid_reg || s1_advance);
    assign s_accept   = s_tvalid && s_tready;
    assign wr_en      = s1_advance && s1_range_reg;

    pfsm_store #(
        .DEPTH     (THREAD_COUNT),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (s1_item_reg.thread_id[ADDR_BITS-1:0]),
        .wr_data  (new_entry),
        .rd_en    (s_accept),
        .rd_addr  (in_item.thread_id[ADDR_BITS-1:0]),
        .rd_data  (rd_entry),
        .clearing (clearing)
    );

    // write landing in the same edge as the read is not seen by the memory
    assign cur_entry = fwd_hit_reg ? fwd_data_reg : rd_entry;

    pfsm_update #(
        .COUNTER_BITS (COUNTER_BITS),
        .ENTRY_BITS   (ENTRY_BITS)
    ) u_update (
        .item           (s1_item_reg),
        .in_range       (s1_range_reg),
        .entry_in       (cur_entry),
        .entry_out      (new_entry),
        .thread_valid   (t_valid),
        .thread_invalid (t_invalid),
        .thread_break   (t_break),
        .seq_break      (brk)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        s1_range_next = s1_range_reg;
        fwd_hit_next  = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
            s1_item_next  = in_item;
            s1_range_next = in_range;
            fwd_hit_next  = wr_en && (s1_item_reg.thread_id == in_item.thread_id);
            fwd_data_next = new_entry;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    // global statistics and the result transaction
    always_comb begin
        highest_next       = highest_reg;
        valid_total_next   = valid_total_reg;
        invalid_total_next = invalid_total_reg;
        m_valid_next       = m_valid_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s1_advance) begin
            if (s1_item_reg.frame_number > highest_reg) begin
                highest_next = s1_item_reg.frame_number;
            end
            if (s1_item_reg.frame_invalid) begin
                if (invalid_total_reg != '1) invalid_total_next = invalid_total_reg + 1'b1;
            end else begin
                if (valid_total_reg != '1) valid_total_next = valid_total_reg + 1'b1;
            end
            m_valid_next = 1'b1;
            m_tdata_next = {OUT_CNT_BITS'(invalid_total_next),
                            OUT_CNT_BITS'(valid_total_next),
                            highest_next,
                            OUT_CNT_BITS'(t_break),
                            OUT_CNT_BITS'(t_invalid),
                            OUT_CNT_BITS'(t_valid)};
            m_tuser_next = brk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            fwd_hit_reg       <= 1'b0;
            highest_reg       <= '0;
            valid_total_reg   <= '0;
            invalid_total_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            s1_valid_reg      <= s1_valid_next;
            fwd_hit_reg       <= fwd_hit_next;
            highest_reg       <= highest_next;
            valid_total_reg   <= valid_total_next;
            invalid_total_reg <= invalid_total_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_item_reg  <= s1_item_next;
        s1_range_reg <= s1_range_next;
        fwd_data_reg <= fwd_data_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- tb/tb_per_thread_frame_sequence_monitor.sv -----
// self-checking testbench of the per-thread frame sequence monitor
module tb_per_thread_frame_sequence_monitor;
    import pfsm_pkg::*;

    localparam int THREADS        = 1024;
    localparam int RANDOM_HEADERS = 400;
    localparam int POOL_SIZE      = 8;
    // covers the sweep of the per-thread memory, then roughly 420 headers
    localparam int CYCLE_LIMIT    = 200000;

    typedef bit [OUT_CNT_BITS-1:0] count_t;

    // one result transaction, split into its fields
    typedef struct {
        count_t                thread_valid;
        count_t                thread_invalid;
        count_t                thread_breaks;
        bit                    seq_break;
        bit [FRAME_BITS-1:0]   highest;
        count_t                all_valid;
        count_t                all_invalid;
    } frame_stats_t;

    // predicts the statistics after each accepted header and checks results in order
    class frame_stats_board;
        frame_stats_t          stats_q[$];
        bit                    seen[THREADS];
        bit [FRAME_BITS-1:0]   last_frame[THREADS];
        count_t                valid_cnt[THREADS];
        count_t                invalid_cnt[THREADS];
        count_t                break_cnt[THREADS];
        bit [FRAME_BITS-1:0]   highest;
        count_t                valid_sum;
        count_t                invalid_sum;
        int                    errors;

        // counters hold at all ones
        function count_t bump(input count_t v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void note_header(input bit [TID_BITS-1:0] tid,
                                  input bit [FRAME_BITS-1:0] frame, input bit bad);
            frame_stats_t s;
            s.thread_valid   = '0;
            s.thread_invalid = '0;
            s.thread_breaks  = '0;
            s.seq_break      = 1'b0;
            if (frame > highest)
                highest = frame;
            if (bad)
                invalid_sum = bump(invalid_sum);
            else
                valid_sum = bump(valid_sum);
            if (tid < THREADS) begin
                if (bad)
                    invalid_cnt[tid] = bump(invalid_cnt[tid]);
                else
                    valid_cnt[tid] = bump(valid_cnt[tid]);
                // the successor of the last frame is formed one bit wider, so no wrap
                if (seen[tid] && frame != '0 &&
                    {1'b0, frame} != {1'b0, last_frame[tid]} + 1'b1) begin
                    s.seq_break    = 1'b1;
                    break_cnt[tid] = bump(break_cnt[tid]);
                end
                seen[tid]        = 1'b1;
                last_frame[tid]  = frame;
                s.thread_valid   = valid_cnt[tid];
                s.thread_invalid = invalid_cnt[tid];
                s.thread_breaks  = break_cnt[tid];
            end
            s.highest     = highest;
            s.all_valid   = valid_sum;
            s.all_invalid = invalid_sum;
            stats_q.push_back(s);
        endfunction

        function void compare(input string field, input count_t want, input count_t got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(input bit [M_TDATA_BITS-1:0] data, input bit brk);
            frame_stats_t want;
            if (stats_q.size() == 0) begin
                $error("result transaction with no header outstanding");
                errors++;
                return;
            end
            want = stats_q.pop_front();
            compare("thread_valid_frames", want.thread_valid, data[31:0]);
            compare("thread_invalid_frames", want.thread_invalid, data[63:32]);
            compare("thread_out_of_sequence", want.thread_breaks, data[95:64]);
            compare("sequence_break", count_t'(want.seq_break), count_t'(brk));
            compare("highest_frame_seen", count_t'(want.highest), count_t'(data[119:96]));
            compare("all_valid_frames", want.all_valid, data[151:120]);
            compare("all_invalid_frames", want.all_invalid, data[183:152]);
        endfunction
    endclass

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tuser;

    frame_stats_board board;
    bit               calm = 1'b0;     // no idling on either side while set
    int               cycle_count = 0;

    per_thread_frame_sequence_monitor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: sample the transaction at the edge, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // offer one header, with random idle cycles ahead of it, and hold until taken
    task automatic send_header(input bit [TID_BITS-1:0] tid,
                               input bit [FRAME_BITS-1:0] frame, input bit bad);
        while (!calm && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_BITS - TID_BITS - FRAME_BITS){1'b0}}, frame, tid};
        s_tuser  <= bad;
        do
            @(posedge aclk);
        while (!s_tready);
        board.note_header(tid, frame, bad);
    endtask

    initial begin
        bit [TID_BITS-1:0]   pool[POOL_SIZE];
        bit [TID_BITS-1:0]   tid;
        bit [FRAME_BITS-1:0] frame;
        int                  roll;

        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // first frame of a thread, in sequence, a jump with the invalid flag, a restart at zero
        send_header(10'd0, 24'd0, 1'b0);
        send_header(10'd0, 24'd1, 1'b0);
        send_header(10'd0, 24'd5, 1'b1);
        send_header(10'd0, 24'd0, 1'b0);
        // top frame number: only zero follows it, one is a break since there is no wrap
        send_header(10'd1023, 24'hFFFFFF, 1'b0);
        send_header(10'd1023, 24'd0, 1'b0);
        send_header(10'd1023, 24'hFFFFFF, 1'b1);
        send_header(10'd1023, 24'd1, 1'b0);
        // invalid frames still keep the sequence, a repeated number breaks it
        send_header(10'd512, 24'd100, 1'b1);
        send_header(10'd512, 24'd101, 1'b1);
        send_header(10'd512, 24'd101, 1'b0);
        // alternating bit patterns on every field
        send_header(10'd341, 24'hAAAAAA, 1'b0);
        send_header(10'd682, 24'h555555, 1'b1);
        send_header(10'd341, 24'hAAAAAB, 1'b0);
        send_header(10'd682, 24'h000002, 1'b0);
        // back-to-back headers of one thread go through the forwarding path
        calm = 1'b1;
        send_header(10'd7, 24'd1, 1'b0);
        send_header(10'd7, 24'd2, 1'b0);
        send_header(10'd7, 24'd3, 1'b1);
        send_header(10'd7, 24'd9, 1'b0);
        send_header(10'd7, 24'd9, 1'b0);
        send_header(10'd8, 24'd4, 1'b0);
        send_header(10'd7, 24'd10, 1'b0);
        calm = 1'b0;

        foreach (pool[k])
            pool[k] = TID_BITS'($urandom_range(THREADS - 1));

        // mostly in-sequence streams on a few threads, with restarts, jumps and stray threads
        for (int n = 0; n < RANDOM_HEADERS; n++) begin
            calm = (n >= 150 && n < 250);
            roll = $urandom_range(99);
            tid  = pool[$urandom_range(POOL_SIZE - 1)];
            if (roll < 70)
                frame = board.last_frame[tid] + 1'b1;
            else if (roll < 80)
                frame = '0;
            else if (roll < 90)
                frame = FRAME_BITS'($urandom_range(24'hFFFFFF));
            else begin
                tid   = TID_BITS'($urandom_range(THREADS - 1));
                frame = FRAME_BITS'($urandom_range(24'hFFFFFF));
            end
            send_header(tid, frame, $urandom_range(99) < 10);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (board.stats_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- per_thread_frame_sequence_monitor.f -----
rtl/core/pfsm_pkg.sv
rtl/core/pfsm_store.sv
rtl/core/pfsm_update.sv
rtl/core/per_thread_frame_sequence_monitor.sv
tb/tb_per_thread_frame_sequence_monitor.sv
